// File: rtl/core/svf_pkg.sv
// Shared widths, register indexes, types and saturation helpers of the state-variable filter.
package svf_pkg;

   localparam int SAMPLE_W     = 16;
   localparam int COEF_W       = 16;
   localparam int STATE_W      = 24;
   localparam int SCALED_W     = 21;
   localparam int OPA_W        = 17;
   localparam int OPB_W        = 25;
   localparam int PROD_W       = OPA_W + OPB_W;
   localparam int ACC_W        = PROD_W + 2;
   localparam int SUM_W        = 28;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 16;
   localparam int OVERSAMPLE_DEF = 2;

   localparam logic [CSR_IDX_W-1:0] REG_DAMPING     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INPUT_SCALE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_DRY    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_LOW    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_HIGH   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_BAND   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_NOTCH  = 3'd6;

   localparam logic [15:0] DAMPING_RST     = 16'd32768;
   localparam logic [15:0] INPUT_SCALE_RST = 16'd32768;
   localparam logic [15:0] GAIN_LOW_RST    = 16'd16384;

   typedef struct packed {
      logic        [15:0] damping;
      logic        [15:0] input_scale;
      logic signed [15:0] gain_dry;
      logic signed [15:0] gain_low;
      logic signed [15:0] gain_high;
      logic signed [15:0] gain_band;
      logic signed [15:0] gain_notch;
   } cfg_type;

   typedef struct packed {
      logic mul_en;
      logic acc_en;
      logic acc_clr;
   } mac_ctrl_type;

   function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'(signed'({1'b0, {(STATE_W-1){1'b1}}}));
      lo = -hi - SUM_W'(1);
      if (v > hi) return {1'b0, {(STATE_W-1){1'b1}}};
      else if (v < lo) return {1'b1, {(STATE_W-1){1'b0}}};
      else return v[STATE_W-1:0];
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] sat_sample(
      input logic signed [ACC_W-19:0] v);
      logic signed [ACC_W-19:0] hi;
      logic signed [ACC_W-19:0] lo;
      hi = (ACC_W-18)'(signed'({1'b0, {(SAMPLE_W-1){1'b1}}}));
      lo = -hi - (ACC_W-18)'(1);
      if (v > hi) return {1'b0, {(SAMPLE_W-1){1'b1}}};
      else if (v < lo) return {1'b1, {(SAMPLE_W-1){1'b0}}};
      else return v[SAMPLE_W-1:0];
   endfunction

endpackage

// File: rtl/core/svf_if.sv
// Channel interfaces of the filter: sample request, mixed response and register write.
interface svf_req_if import svf_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_in;
   logic        [COEF_W-1:0]   freq_coef;
   modport source (output valid, sample_in, freq_coef, input ready);
   modport sink   (input valid, sample_in, freq_coef, output ready);
endinterface

interface svf_rsp_if import svf_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_out;
   modport source (output valid, sample_out, input ready);
   modport sink   (input valid, sample_out, output ready);
endinterface

interface svf_csr_if import svf_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/svf_regs.sv
// Register file for damping, input scale and the five mix gains.
module svf_regs import svf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   svf_csr_if.sink    csr_chan,
   output cfg_type    cfg
);

   cfg_type cfg_ff, cfg_in;

   assign csr_chan.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_DAMPING:     cfg_in.damping     = csr_chan.data;
            REG_INPUT_SCALE: cfg_in.input_scale = csr_chan.data;
            REG_GAIN_DRY:    cfg_in.gain_dry    = csr_chan.data;
            REG_GAIN_LOW:    cfg_in.gain_low    = csr_chan.data;
            REG_GAIN_HIGH:   cfg_in.gain_high   = csr_chan.data;
            REG_GAIN_BAND:   cfg_in.gain_band   = csr_chan.data;
            REG_GAIN_NOTCH:  cfg_in.gain_notch  = csr_chan.data;
            default: ;  // unknown index: transaction dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.damping     <= DAMPING_RST;
         cfg_ff.input_scale <= INPUT_SCALE_RST;
         cfg_ff.gain_dry    <= '0;
         cfg_ff.gain_low    <= GAIN_LOW_RST;
         cfg_ff.gain_high   <= '0;
         cfg_ff.gain_band   <= '0;
         cfg_ff.gain_notch  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/core/svf_mac.sv
// Shared 17x25 signed multiplier with registered product and a mix accumulator.
module svf_mac import svf_pkg::*; (
   input  logic                     clock,
   input  mac_ctrl_type             ctrl,
   input  logic signed [OPA_W-1:0]  op_a,
   input  logic signed [OPB_W-1:0]  op_b,
   output logic signed [PROD_W-1:0] prod,
   output logic signed [ACC_W-1:0]  acc
);

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;

   assign prod = prod_ff;
   assign acc  = acc_ff;

   always_comb begin
      prod_in = prod_ff;
      acc_in  = acc_ff;
      if (ctrl.mul_en) prod_in = op_a * op_b;
      if (ctrl.acc_en) acc_in = (ctrl.acc_clr ? '0 : acc_ff) + ACC_W'(prod_ff);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

endmodule

// File: rtl/core/state_variable_filter_mix.sv
// Chamberlin state-variable filter with oversampled update and five-way output mix.
//
// req_chan takes one sample and its frequency coefficient per transaction; rsp_chan
// returns the saturated mixed output, one transaction per request, in order.
// csr_chan writes the seven registers (index 0..6, others ignored); it is always ready
// and is meant to be written only while no sample is in flight.
// Every product goes through one shared 17x25 multiplier, each as an operand-issue state
// (ST_MUL) followed by a write-back state (ST_USE): one input scaling, three products per
// filter pass and five mix products; then ST_OUT loads the output register. The result
// appears in the output register in the same cycle that req_chan.ready returns, so a new
// sample is accepted only after the previous one has finished.
// The output register lets a new request in while a result waits; if the receiver
// still stalls when the next result is ready, the sequencer holds until it is taken.
// Synchronous reset clears the low-pass and band-pass state, restores the register
// defaults and empties the output register.
module state_variable_filter_mix import svf_pkg::*; #(
   parameter int OVERSAMPLE = OVERSAMPLE_DEF
) (
   input  logic     clock,
   input  logic     reset,
   svf_req_if.sink  req_chan,
   svf_rsp_if.source rsp_chan,
   svf_csr_if.sink  csr_chan
);

   localparam int PASS_W = (OVERSAMPLE > 1) ? $clog2(OVERSAMPLE) : 1;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_USE  = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   typedef enum logic [3:0] {
      OP_SCALE, OP_LOW, OP_HIGH, OP_BAND,
      OP_MIX_DRY, OP_MIX_LOW, OP_MIX_HIGH, OP_MIX_BAND, OP_MIX_NOTCH
   } op_type;

   cfg_type      cfg;
   mac_ctrl_type mac_ctrl;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic [PASS_W-1:0] pass_ff, pass_in;
   logic signed [SAMPLE_W-1:0] x_ff, x_in;
   logic        [COEF_W-1:0]   f_ff, f_in;
   logic signed [SCALED_W-1:0] scaled_ff, scaled_in;
   logic signed [STATE_W-1:0]  low_ff, low_in, band_ff, band_in, high_ff, high_in;
   logic signed [SAMPLE_W-1:0] rsp_data_ff, rsp_data_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   logic signed [OPA_W-1:0]  op_a;
   logic signed [OPB_W-1:0]  op_b;
   logic signed [PROD_W-1:0] prod;
   logic signed [ACC_W-1:0]  acc;
   logic signed [OPB_W-1:0]  xs_ext, low_ext, band_ext, high_ext, notch;
   logic signed [PROD_W-17:0] p16;
   logic signed [PROD_W-16:0] p15;
   logic signed [SUM_W-1:0]   low_sum, high_sum, band_sum;
   logic                      last_pass;

   svf_regs u_regs (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   svf_mac u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod),
      .acc   (acc)
   );

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.sample_out = rsp_data_ff;

   // state carries 4 fraction bits, so the dry term is x << 4
   assign xs_ext   = OPB_W'(signed'({x_ff, 4'b0000}));
   assign low_ext  = OPB_W'(low_ff);
   assign band_ext = OPB_W'(band_ff);
   assign high_ext = OPB_W'(high_ff);
   assign notch    = high_ext + low_ext;

   assign p16 = prod[PROD_W-1:16];
   assign p15 = prod[PROD_W-1:15];
   assign low_sum  = SUM_W'(low_ff) + SUM_W'(p16);
   assign high_sum = SUM_W'(scaled_ff) - SUM_W'(low_ff) - SUM_W'(p15);
   assign band_sum = SUM_W'(band_ff) + SUM_W'(p16);
   assign last_pass = (pass_ff == PASS_W'(OVERSAMPLE - 1));

   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (op_ff)
         OP_SCALE:     begin op_a = {1'b0, cfg.input_scale}; op_b = xs_ext;   end
         OP_LOW:       begin op_a = {1'b0, f_ff};            op_b = band_ext; end
         OP_HIGH:      begin op_a = {1'b0, cfg.damping};     op_b = band_ext; end
         OP_BAND:      begin op_a = {1'b0, f_ff};            op_b = high_ext; end
         OP_MIX_DRY:   begin op_a = OPA_W'(cfg.gain_dry);    op_b = xs_ext;   end
         OP_MIX_LOW:   begin op_a = OPA_W'(cfg.gain_low);    op_b = low_ext;  end
         OP_MIX_HIGH:  begin op_a = OPA_W'(cfg.gain_high);   op_b = high_ext; end
         OP_MIX_BAND:  begin op_a = OPA_W'(cfg.gain_band);   op_b = band_ext; end
         OP_MIX_NOTCH: begin op_a = OPA_W'(cfg.gain_notch);  op_b = notch;    end
         default: ;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      pass_in      = pass_ff;
      x_in         = x_ff;
      f_in         = f_ff;
      scaled_in    = scaled_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      band_in      = band_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      mac_ctrl     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               x_in     = req_chan.sample_in;
               f_in     = req_chan.freq_coef;
               op_in    = OP_SCALE;
               pass_in  = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            mac_ctrl.mul_en = 1'b1;
            state_in        = ST_USE;
         end
         ST_USE: begin
            state_in = ST_MUL;
            case (op_ff)
               OP_SCALE: begin
                  scaled_in = prod[SCALED_W+14:15];
                  op_in     = OP_LOW;
               end
               OP_LOW: begin
                  low_in = sat_state(low_sum);
                  op_in  = OP_HIGH;
               end
               OP_HIGH: begin
                  high_in = sat_state(high_sum);
                  op_in   = OP_BAND;
               end
               OP_BAND: begin
                  band_in = sat_state(band_sum);
                  if (last_pass) begin
                     op_in = OP_MIX_DRY;
                  end else begin
                     pass_in = pass_ff + PASS_W'(1);
                     op_in   = OP_LOW;
                  end
               end
               OP_MIX_DRY: begin
                  mac_ctrl.acc_en  = 1'b1;
                  mac_ctrl.acc_clr = 1'b1;
                  op_in            = OP_MIX_LOW;
               end
               OP_MIX_LOW: begin
                  mac_ctrl.acc_en = 1'b1;
                  op_in           = OP_MIX_HIGH;
               end
               OP_MIX_HIGH: begin
                  mac_ctrl.acc_en = 1'b1;
                  op_in           = OP_MIX_BAND;
               end
               OP_MIX_BAND: begin
                  mac_ctrl.acc_en = 1'b1;
                  op_in           = OP_MIX_NOTCH;
               end
               OP_MIX_NOTCH: begin
                  mac_ctrl.acc_en = 1'b1;
                  state_in        = ST_OUT;
               end
               default: ;
            endcase
         end
         ST_OUT: begin
            // wait while the previous result is still held by the receiver
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_data_in  = sat_sample(acc[ACC_W-1:18]);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_SCALE;
         pass_ff      <= '0;
         low_ff       <= '0;
         band_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         pass_ff      <= pass_in;
         low_ff       <= low_in;
         band_ff      <= band_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      f_ff        <= f_in;
      scaled_ff   <= scaled_in;
      high_ff     <= high_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef NO_ASSERTIONS
   a_accept_starts_scale: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (state_ff == ST_MUL && op_ff == OP_SCALE))
      else $error("accepted request did not start the input scaling product");

   a_out_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && (!rsp_valid_ff || rsp_chan.ready)) |=> rsp_valid_ff)
      else $error("finished result not placed in the output register");

   a_state_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_USE) |=> ($stable(low_ff) && $stable(band_ff)))
      else $error("filter state changed outside a write-back cycle");

   a_pass_bound: assert property (@(posedge clock) disable iff (reset)
      pass_ff <= PASS_W'(OVERSAMPLE - 1))
      else $error("pass counter beyond the oversampling count");
`endif

endmodule
